/* rtl/core/ghe_pkg.sv */
package ghe_pkg;

  // Default build parameters
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_BITS_DEF    = 16;

  // Field widths
  localparam int QUAT_W   = 16;
  localparam int POS_W    = 32;
  localparam int ANGLE_OUT_W = 16;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;

  // Datapath widths: the yaw terms need 34 bits signed, the goal vector 33.
  // Operands are scaled by 2^20 before rotation and gain stays below 2^2.
  localparam int TERM_W      = 34;
  localparam int PRESCALE_SH = 20;
  localparam int CW          = TERM_W + PRESCALE_SH + 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_POS_X = 1'b0,
    REG_GOAL_POS_Y = 1'b1
  } cfg_reg_t;

  // One vector in flight through the rotation chain
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } cvec_t;

  // Per-item side data that rides along the chain
  typedef struct packed {
    logic             yaw_zero;
    logic             brg_zero;
    logic [POS_W-1:0] echo_x;
    logic [POS_W-1:0] echo_y;
  } side_t;

  // atan(2^-i) in 2^32-per-turn units
  localparam int ATAN_LEN = 24;
  localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Round the table entry to nearest at the given angle width
  function automatic logic [31:0] atan_step(input int idx, input int abits);
    logic [32:0] t;
    int          sh;
    t  = {1'b0, ATAN_TURN32[idx]};
    sh = 32 - abits;
    if (sh == 0) begin
      return t[31:0];
    end
    return 32'((t + (33'd1 << (sh - 1))) >> sh);
  endfunction

endpackage

/* rtl/core/ghe_prep.sv */
module ghe_prep #(
  parameter int ANGLE_BITS = ghe_pkg::ANGLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 valid_i,
  input  logic signed [ghe_pkg::QUAT_W-1:0]    quat_w,
  input  logic signed [ghe_pkg::QUAT_W-1:0]    quat_x,
  input  logic signed [ghe_pkg::QUAT_W-1:0]    quat_y,
  input  logic signed [ghe_pkg::QUAT_W-1:0]    quat_z,
  input  logic signed [ghe_pkg::POS_W-1:0]     pos_x,
  input  logic signed [ghe_pkg::POS_W-1:0]     pos_y,
  input  logic signed [ghe_pkg::POS_W-1:0]     goal_x,
  input  logic signed [ghe_pkg::POS_W-1:0]     goal_y,
  output logic                                 valid_o,
  output ghe_pkg::side_t                       side_o,
  output ghe_pkg::cvec_t                       yaw_o,
  output logic [ANGLE_BITS-1:0]                yaw_z_o,
  output ghe_pkg::cvec_t                       brg_o,
  output logic [ANGLE_BITS-1:0]                brg_z_o
);
  import ghe_pkg::*;

  localparam logic [ANGLE_BITS-1:0] Z_HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  // Stage 1: quaternion products and goal vector
  logic                    valid1_r;
  logic signed [31:0]      p_wz_r, p_xy_r, p_yy_r, p_zz_r;
  logic signed [POS_W:0]   dx_r, dy_r;
  logic [POS_W-1:0]        echo_x_r, echo_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else if (adv) begin
      valid1_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_wz_r   <= quat_w * quat_z;
      p_xy_r   <= quat_x * quat_y;
      p_yy_r   <= quat_y * quat_y;
      p_zz_r   <= quat_z * quat_z;
      dx_r     <= {goal_x[POS_W-1], goal_x} - {pos_x[POS_W-1], pos_x};
      dy_r     <= {goal_y[POS_W-1], goal_y} - {pos_y[POS_W-1], pos_y};
      echo_x_r <= pos_x;
      echo_y_r <= pos_y;
    end
  end

  // Stage 2: yaw terms, scale up, turn left-half-plane vectors by pi
  logic signed [TERM_W-1:0] sin_t, cos_t, bdx_t, bdy_t;
  logic signed [TERM_W-1:0] sum_sin, sum_sq;
  logic signed [CW-1:0]     ysx, ysy, bsx, bsy;
  logic                     yaw_neg, brg_neg;

  always_comb begin
    sum_sin = TERM_W'(p_wz_r) + TERM_W'(p_xy_r);
    sum_sq  = TERM_W'(p_yy_r) + TERM_W'(p_zz_r);
    sin_t   = sum_sin <<< 1;
    cos_t   = (TERM_W'(1) <<< 28) - (sum_sq <<< 1);
    bdx_t   = TERM_W'(dx_r);
    bdy_t   = TERM_W'(dy_r);
    ysx     = CW'(cos_t) <<< PRESCALE_SH;
    ysy     = CW'(sin_t) <<< PRESCALE_SH;
    bsx     = CW'(bdx_t) <<< PRESCALE_SH;
    bsy     = CW'(bdy_t) <<< PRESCALE_SH;
    yaw_neg = cos_t[TERM_W-1];
    brg_neg = bdx_t[TERM_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yaw_o.x         <= yaw_neg ? -ysx : ysx;
      yaw_o.y         <= yaw_neg ? -ysy : ysy;
      yaw_z_o         <= yaw_neg ? Z_HALF : '0;
      brg_o.x         <= brg_neg ? -bsx : bsx;
      brg_o.y         <= brg_neg ? -bsy : bsy;
      brg_z_o         <= brg_neg ? Z_HALF : '0;
      side_o.yaw_zero <= (sin_t == '0) && (cos_t == '0);
      side_o.brg_zero <= (bdx_t == '0) && (bdy_t == '0);
      side_o.echo_x   <= echo_x_r;
      side_o.echo_y   <= echo_y_r;
    end
  end

endmodule

/* rtl/core/ghe_cordic_cell.sv */
module ghe_cordic_cell #(
  parameter int ANGLE_BITS = ghe_pkg::ANGLE_BITS_DEF,
  parameter int STAGE_IDX  = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  valid_i,
  input  ghe_pkg::side_t        side_i,
  input  ghe_pkg::cvec_t        yaw_i,
  input  logic [ANGLE_BITS-1:0] yaw_z_i,
  input  ghe_pkg::cvec_t        brg_i,
  input  logic [ANGLE_BITS-1:0] brg_z_i,
  output logic                  valid_o,
  output ghe_pkg::side_t        side_o,
  output ghe_pkg::cvec_t        yaw_o,
  output logic [ANGLE_BITS-1:0] yaw_z_o,
  output ghe_pkg::cvec_t        brg_o,
  output logic [ANGLE_BITS-1:0] brg_z_o
);
  import ghe_pkg::*;

  localparam logic [ANGLE_BITS-1:0] STEP = ANGLE_BITS'(atan_step(STAGE_IDX, ANGLE_BITS));

  // Shifted copies round toward minus infinity
  logic signed [CW-1:0] yx_sh, yy_sh, bx_sh, by_sh;
  logic                 yaw_pos, brg_pos;

  always_comb begin
    yx_sh   = yaw_i.x >>> STAGE_IDX;
    yy_sh   = yaw_i.y >>> STAGE_IDX;
    bx_sh   = brg_i.x >>> STAGE_IDX;
    by_sh   = brg_i.y >>> STAGE_IDX;
    yaw_pos = !yaw_i.y[CW-1];
    brg_pos = !brg_i.y[CW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= valid_i;
    end
  end

  // Rotate both vectors toward the x axis
  always_ff @(posedge clk) begin
    if (adv) begin
      side_o  <= side_i;
      yaw_o.x <= yaw_pos ? yaw_i.x + yy_sh : yaw_i.x - yy_sh;
      yaw_o.y <= yaw_pos ? yaw_i.y - yx_sh : yaw_i.y + yx_sh;
      yaw_z_o <= yaw_pos ? yaw_z_i + STEP  : yaw_z_i - STEP;
      brg_o.x <= brg_pos ? brg_i.x + by_sh : brg_i.x - by_sh;
      brg_o.y <= brg_pos ? brg_i.y - bx_sh : brg_i.y + bx_sh;
      brg_z_o <= brg_pos ? brg_z_i + STEP  : brg_z_i - STEP;
    end
  end

endmodule

/* rtl/core/goal_heading_error.sv */
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_ready   | quat_w/x/y/z (Q1.14), pos_x/y (Q16.16)
// out_    | output    | out_valid/out_ready | heading_error, yaw_angle, echo_x/y
// cfg_    | input     | cfg_we              | cfg_index, cfg_data (goal x/y)
//
// One pose is taken per cycle while the output register is not stalled.
// Each pose passes two front stages (products, then scaling and pre-rotation), one
// rotation cell per CORDIC stage, and the output register.
// Reset clears all valid bits and both goal registers to zero.
// A stalled output register freezes the whole chain; input ready follows it.
module goal_heading_error #(
  parameter int CORDIC_STAGES = ghe_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_BITS    = ghe_pkg::ANGLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ghe_pkg::QUAT_W-1:0]      in_quat_w,
  input  logic signed [ghe_pkg::QUAT_W-1:0]      in_quat_x,
  input  logic signed [ghe_pkg::QUAT_W-1:0]      in_quat_y,
  input  logic signed [ghe_pkg::QUAT_W-1:0]      in_quat_z,
  input  logic signed [ghe_pkg::POS_W-1:0]       in_pos_x,
  input  logic signed [ghe_pkg::POS_W-1:0]       in_pos_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ghe_pkg::ANGLE_OUT_W-1:0] out_heading_error,
  output logic signed [ghe_pkg::ANGLE_OUT_W-1:0] out_yaw_angle,
  output logic signed [ghe_pkg::POS_W-1:0]       out_echo_x,
  output logic signed [ghe_pkg::POS_W-1:0]       out_echo_y,
  input  logic                                   cfg_we,
  input  logic [ghe_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ghe_pkg::CFG_W-1:0]              cfg_data
);
  import ghe_pkg::*;

  // Goal registers
  logic signed [POS_W-1:0] goal_x_r, goal_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r <= '0;
      goal_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_POS_X: goal_x_r <= cfg_data;
        REG_GOAL_POS_Y: goal_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the chain whenever the output register is free or being drained
  logic out_valid_r;
  logic adv;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Chain taps: entry 0 is the front end, entry i+1 the output of cell i
  logic                  cell_valid [CORDIC_STAGES+1];
  side_t                 cell_side  [CORDIC_STAGES+1];
  cvec_t                 cell_yaw   [CORDIC_STAGES+1];
  logic [ANGLE_BITS-1:0] cell_yaw_z [CORDIC_STAGES+1];
  cvec_t                 cell_brg   [CORDIC_STAGES+1];
  logic [ANGLE_BITS-1:0] cell_brg_z [CORDIC_STAGES+1];

  ghe_prep #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (in_valid),
    .quat_w  (in_quat_w),
    .quat_x  (in_quat_x),
    .quat_y  (in_quat_y),
    .quat_z  (in_quat_z),
    .pos_x   (in_pos_x),
    .pos_y   (in_pos_y),
    .goal_x  (goal_x_r),
    .goal_y  (goal_y_r),
    .valid_o (cell_valid[0]),
    .side_o  (cell_side[0]),
    .yaw_o   (cell_yaw[0]),
    .yaw_z_o (cell_yaw_z[0]),
    .brg_o   (cell_brg[0]),
    .brg_z_o (cell_brg_z[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    ghe_cordic_cell #(
      .ANGLE_BITS (ANGLE_BITS),
      .STAGE_IDX  (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (cell_valid[i]),
      .side_i  (cell_side[i]),
      .yaw_i   (cell_yaw[i]),
      .yaw_z_i (cell_yaw_z[i]),
      .brg_i   (cell_brg[i]),
      .brg_z_i (cell_brg_z[i]),
      .valid_o (cell_valid[i+1]),
      .side_o  (cell_side[i+1]),
      .yaw_o   (cell_yaw[i+1]),
      .yaw_z_o (cell_yaw_z[i+1]),
      .brg_o   (cell_brg[i+1]),
      .brg_z_o (cell_brg_z[i+1])
    );
  end

  // Zero vectors give angle zero; error wraps modulo a full turn
  logic [ANGLE_BITS-1:0]  yaw_a, brg_a, err_a;
  logic [ANGLE_OUT_W-1:0] yaw_16, err_16;
  side_t                  last_side;

  assign last_side = cell_side[CORDIC_STAGES];
  assign yaw_a = last_side.yaw_zero ? '0 : cell_yaw_z[CORDIC_STAGES];
  assign brg_a = last_side.brg_zero ? '0 : cell_brg_z[CORDIC_STAGES];
  assign err_a = brg_a - yaw_a;

  if (ANGLE_BITS >= ANGLE_OUT_W) begin : g_trunc
    assign yaw_16 = yaw_a[ANGLE_BITS-1 -: ANGLE_OUT_W];
    assign err_16 = err_a[ANGLE_BITS-1 -: ANGLE_OUT_W];
  end else begin : g_pad
    assign yaw_16 = {yaw_a, {(ANGLE_OUT_W-ANGLE_BITS){1'b0}}};
    assign err_16 = {err_a, {(ANGLE_OUT_W-ANGLE_BITS){1'b0}}};
  end

  // Output register
  logic [ANGLE_OUT_W-1:0] heading_error_r, yaw_angle_r;
  logic [POS_W-1:0]       echo_x_r, echo_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cell_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heading_error_r <= err_16;
      yaw_angle_r     <= yaw_16;
      echo_x_r        <= last_side.echo_x;
      echo_y_r        <= last_side.echo_y;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_heading_error = heading_error_r;
  assign out_yaw_angle     = yaw_angle_r;
  assign out_echo_x        = echo_x_r;
  assign out_echo_y        = echo_y_r;

  // A stall freezes the last cell
  a_stall_holds_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cell_valid[CORDIC_STAGES]))
    else $error("last cell changed during stall");

  // A new result only comes from a valid last cell
  a_out_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cell_valid[CORDIC_STAGES]))
    else $error("result appeared without an item in the chain");

  // A bubble at the end of the chain empties the output register
  a_bubble_clears_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !cell_valid[CORDIC_STAGES] |=> !out_valid_r)
    else $error("result repeated after transfer");

endmodule

/* tb/tb_goal_heading_error.sv */
module tb_goal_heading_error;
  timeunit 1ns;
  timeprecision 1ps;

  import ghe_pkg::*;

  localparam int N_STAGES = CORDIC_STAGES_DEF;
  localparam int ANG_BITS = ANGLE_BITS_DEF;
  localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANG_BITS) - 64'd1);
  localparam int SETTLE_CYCLES = N_STAGES + 3 + 4;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 64;
  localparam int RAND_PHASES = 6;
  localparam int POSES_PER_PHASE = 225;

  typedef struct packed {
    logic signed [QUAT_W-1:0] qw;
    logic signed [QUAT_W-1:0] qx;
    logic signed [QUAT_W-1:0] qy;
    logic signed [QUAT_W-1:0] qz;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
  } pose_t;

  typedef struct packed {
    logic signed [ANGLE_OUT_W-1:0] err;
    logic signed [ANGLE_OUT_W-1:0] yaw;
    logic signed [POS_W-1:0]       ex;
    logic signed [POS_W-1:0]       ey;
  } heading_t;

  // Predicts heading results for accepted poses and checks them in order
  class heading_board;
    int       goal_x;
    int       goal_y;
    heading_t heading_q[$];
    int       errors;

    function new();
      goal_x = 0;
      goal_y = 0;
      errors = 0;
    endfunction

    function void set_goal(cfg_reg_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_GOAL_POS_X: goal_x = value;
        REG_GOAL_POS_Y: goal_y = value;
        default: ;
      endcase
    endfunction

    // Table entry rounded to nearest at the angle width
    function logic [31:0] turn_step(int i);
      longint t;
      int     sh;
      t  = ATAN_TURN32[i];
      sh = 32 - ANG_BITS;
      if (sh == 0) begin
        return t[31:0];
      end
      return 32'((t + (longint'(1) <<< (sh - 1))) >>> sh);
    endfunction

    // Vectoring rotation: angle of (x, y) in angle-width units
    function logic [31:0] vector_angle(longint y, longint x);
      logic [31:0] z;
      longint      xs;
      longint      ys;
      z = '0;
      if (x == 0 && y == 0) begin
        return '0;
      end
      x = x * (longint'(1) <<< 20);
      y = y * (longint'(1) <<< 20);
      // left half plane: turn by half a circle first
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'd1 << (ANG_BITS - 1);
      end
      for (int i = 0; i < N_STAGES && i < ATAN_LEN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + turn_step(i);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - turn_step(i);
        end
      end
      return z & ANG_MASK;
    endfunction

    function logic [15:0] to_out16(logic [31:0] a);
      int sh;
      a = a & ANG_MASK;
      if (ANG_BITS >= 16) begin
        sh = ANG_BITS - 16;
        return 16'(a >> sh);
      end
      sh = 16 - ANG_BITS;
      return 16'(a << sh);
    endfunction

    function void note_pose(pose_t p);
      longint      w, qx, qy, qz, sin_t, cos_t, dx, dy;
      logic [31:0] yaw, bearing;
      heading_t    h;
      w  = p.qw;
      qx = p.qx;
      qy = p.qy;
      qz = p.qz;
      sin_t = 2 * (w * qz + qx * qy);
      cos_t = (longint'(1) <<< 28) - 2 * (qy * qy + qz * qz);
      dx = longint'(goal_x) - longint'(p.px);
      dy = longint'(goal_y) - longint'(p.py);
      yaw     = vector_angle(sin_t, cos_t);
      bearing = vector_angle(dy, dx);
      h.err = to_out16((bearing - yaw) & ANG_MASK);
      h.yaw = to_out16(yaw);
      h.ex  = p.px;
      h.ey  = p.py;
      heading_q.push_back(h);
    endfunction

    function void check_result(heading_t got);
      heading_t want;
      bit       bad;
      if (heading_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: result with no pending pose: heading_error %0d yaw %0d x %0d y %0d",
                   $time, got.err, got.yaw, got.ex, got.ey);
        end
        return;
      end
      want = heading_q.pop_front();
      bad  = (want !== got);
      if (bad) begin
        errors++;
      end
      if (bad && errors <= MAX_REPORTS) begin
        if (want.err !== got.err) begin
          $display("%0t: heading_error expected %0d got %0d", $time, want.err, got.err);
        end
        if (want.yaw !== got.yaw) begin
          $display("%0t: yaw_angle expected %0d got %0d", $time, want.yaw, got.yaw);
        end
        if (want.ex !== got.ex) begin
          $display("%0t: echo_x expected %0d got %0d", $time, want.ex, got.ex);
        end
        if (want.ey !== got.ey) begin
          $display("%0t: echo_y expected %0d got %0d", $time, want.ey, got.ey);
        end
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [QUAT_W-1:0]      in_quat_w;
  logic signed [QUAT_W-1:0]      in_quat_x;
  logic signed [QUAT_W-1:0]      in_quat_y;
  logic signed [QUAT_W-1:0]      in_quat_z;
  logic signed [POS_W-1:0]       in_pos_x;
  logic signed [POS_W-1:0]       in_pos_y;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [ANGLE_OUT_W-1:0] out_heading_error;
  logic signed [ANGLE_OUT_W-1:0] out_yaw_angle;
  logic signed [POS_W-1:0]       out_echo_x;
  logic signed [POS_W-1:0]       out_echo_y;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_W-1:0]              cfg_data;

  heading_board sb;
  bit           no_idle;
  int unsigned  cycle_count;

  goal_heading_error #(
    .CORDIC_STAGES(N_STAGES),
    .ANGLE_BITS   (ANG_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_quat_w        (in_quat_w),
    .in_quat_x        (in_quat_x),
    .in_quat_y        (in_quat_y),
    .in_quat_z        (in_quat_z),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_heading_error(out_heading_error),
    .out_yaw_angle    (out_yaw_angle),
    .out_echo_x       (out_echo_x),
    .out_echo_y       (out_echo_y),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up after a generous number of cycles
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Record every transfer on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_pose(pose_t'{in_quat_w, in_quat_x, in_quat_y, in_quat_z, in_pos_x, in_pos_y});
      end
      if (out_valid && out_ready) begin
        sb.check_result(heading_t'{out_heading_error, out_yaw_angle, out_echo_x, out_echo_y});
      end
    end
  end

  // Result side: stall a random number of cycles before each transfer
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Hold a pose until it transfers; returns at the following falling edge
  task automatic send_pose(pose_t p);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_quat_w = p.qw;
    in_quat_x = p.qx;
    in_quat_y = p.qy;
    in_quat_z = p.qz;
    in_pos_x  = p.px;
    in_pos_y  = p.py;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop sending and let every pending result come out
  task automatic drain_pipeline();
    in_valid = 1'b0;
    while (sb.heading_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_goal(cfg_reg_t idx, logic [CFG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_goal(idx, value);
    @(negedge clk);
  endtask

  function automatic logic signed [QUAT_W-1:0] rand_quat_part();
    int v;
    case ($urandom_range(0, 9))
      0: return QUAT_W'($urandom);
      1: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      2: return '0;
      default: begin
        v = $urandom_range(0, 32768);
        return QUAT_W'(v - 16384);
      end
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] rand_coord(int g);
    int d;
    case ($urandom_range(0, 7))
      0, 1, 2: return POS_W'($urandom);
      3: begin
        d = $urandom_range(0, 2000);
        return POS_W'(g + d - 1000);
      end
      4: return POS_W'(g);
      5: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: begin
        d = $urandom_range(0, 2 * (1 << 20));
        return POS_W'(d - (1 << 20));
      end
    endcase
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    p.qw = rand_quat_part();
    p.qx = rand_quat_part();
    p.qy = rand_quat_part();
    p.qz = rand_quat_part();
    // now and then a quaternion whose yaw vector is exactly zero
    if ($urandom_range(0, 39) == 0) begin
      p.qw = '0;
      p.qx = '0;
      p.qy = $urandom_range(0, 1) ? 16'sd8192 : -16'sd8192;
      p.qz = $urandom_range(0, 1) ? 16'sd8192 : -16'sd8192;
    end
    p.px = rand_coord(sb.goal_x);
    p.py = rand_coord(sb.goal_y);
    if ($urandom_range(0, 15) == 0) begin
      p.px = sb.goal_x;
      p.py = sb.goal_y;
    end
    return p;
  endfunction

  initial begin
    int d;
    sb        = new();
    rst_n     = 1'b0;
    no_idle   = 1'b0;
    in_valid  = 1'b0;
    in_quat_w = '0;
    in_quat_x = '0;
    in_quat_y = '0;
    in_quat_z = '0;
    in_pos_x  = '0;
    in_pos_y  = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_GOAL_POS_X;
    cfg_data  = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Goal at its reset value (origin)
    send_pose(pose_t'{16384, 0, 0, 0, 0, 0});         // only the goal vector degenerate
    send_pose(pose_t'{0, 0, 8192, 8192, 65536, 0});   // yaw vector is zero
    send_pose(pose_t'{0, 0, 0, 16384, 0, 0});         // yaw exactly half a turn
    send_pose(pose_t'{0, 0, 0, -16384, 65536, 0});    // goal straight ahead
    send_pose(pose_t'{-32768, -32768, -32768, -32768, 32'h7FFFFFFF, 32'h80000000});
    send_pose(pose_t'{32767, 32767, 32767, 32767, 32'h80000000, 32'h7FFFFFFF});
    send_pose(pose_t'{-16384, 16384, -16384, 16384, -1, 1});
    send_pose(pose_t'{11585, 0, 0, 11585, 0, -65536});
    send_pose(pose_t'{16384, -16384, 16384, -16384, 1, 0});
    drain_pipeline();

    // Goal at the far corners
    write_goal(REG_GOAL_POS_X, 32'h7FFFFFFF);
    write_goal(REG_GOAL_POS_Y, 32'h80000000);
    send_pose(pose_t'{16384, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF});
    send_pose(pose_t'{0, 16384, 0, 0, 32'h7FFFFFFF, 32'h80000000}); // at the goal
    send_pose(pose_t'{0, 0, 16384, 0, 32'h7FFFFFFF, 32'h7FFFFFFF});
    send_pose(pose_t'{5000, -7000, 3000, -12000, 32'h80000000, 32'h80000000});
    drain_pipeline();
    write_goal(REG_GOAL_POS_X, 32'h80000000);
    write_goal(REG_GOAL_POS_Y, 32'h7FFFFFFF);
    send_pose(pose_t'{0, 0, 8192, -8192, 32'h80000000, 32'h7FFFFFFF}); // both zero
    send_pose(pose_t'{-16384, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000});
    send_pose(pose_t'{0, 0, 0, 16384, 32'h7FFFFFFF, 32'h7FFFFFFF});

    // Random poses, a new goal for each phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_pipeline();
      case (ph)
        0: begin
          write_goal(REG_GOAL_POS_X, 32'h80000000);
          write_goal(REG_GOAL_POS_Y, 32'h80000000);
        end
        1: begin
          write_goal(REG_GOAL_POS_X, 32'h7FFFFFFF);
          write_goal(REG_GOAL_POS_Y, 32'h7FFFFFFF);
        end
        2: begin
          write_goal(REG_GOAL_POS_X, '0);
          write_goal(REG_GOAL_POS_Y, $urandom);
        end
        3: begin
          d = $urandom_range(0, 2 * (1 << 20));
          write_goal(REG_GOAL_POS_X, CFG_W'(d - (1 << 20)));
          d = $urandom_range(0, 2 * (1 << 20));
          write_goal(REG_GOAL_POS_Y, CFG_W'(d - (1 << 20)));
        end
        default: begin
          write_goal(REG_GOAL_POS_X, $urandom);
          write_goal(REG_GOAL_POS_Y, $urandom);
        end
      endcase
      for (int n = 0; n < POSES_PER_PHASE; n++) begin
        no_idle = ((n / 45) % 4 == 2);
        send_pose(random_pose());
      end
      no_idle = 1'b0;
    end

    drain_pipeline();
    if (sb.errors == 0 && sb.heading_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ghe_pkg.sv
rtl/core/ghe_prep.sv
rtl/core/ghe_cordic_cell.sv
rtl/core/goal_heading_error.sv
tb/tb_goal_heading_error.sv
